// ===== rtl/core/epl_pkg.sv =====
// epl_pkg: shared types and constants for the energy period logger
// no dependencies; used by the controller, datapath and top level
package epl_pkg;

    localparam int SLOTS      = 96;
    localparam int COUNT_BITS = 16;
    localparam int SLOT_BITS  = 8;

    localparam logic [15:0] DARK_RESET = 16'd3500;
    localparam logic [15:0] DARK_LIMIT = 16'd500;
    localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = {COUNT_BITS{1'b1}};

    localparam logic [0:0] CFG_PERIOD  = 1'd0;
    localparam logic [0:0] CFG_LOGGING = 1'd1;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_FLUSH  = 1'b1;

    // which multiply the datapath performs in a step
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_MUL_S1 = 3'd1,
        OP_MUL_S2 = 3'd2,
        OP_MUL_B1 = 3'd3,
        OP_MUL_B2 = 3'd4
    } mul_op_t;

    typedef struct packed {
        logic       load;       // capture input item
        mul_op_t    mul_op;
        logic       sample_upd; // commit sums, peaks, energies
        logic       div_start;  // load divider with sum index div_sel
        logic [1:0] div_sel;
        logic       div_step;
        logic       div_store;  // store quotient into average div_sel
        logic       flush_done; // update totals unless empty, clear period
        logic       out_load;
    } epl_cmd_t;

    typedef struct packed {
        logic is_flush;
        logic empty;
        logic at_limit;
        logic div_last;
    } epl_stat_t;

endpackage

// ===== rtl/core/epl_ctrl.sv =====
// epl_ctrl: sequencing state machine for the energy period logger
// depends on epl_pkg
module epl_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  epl_pkg::epl_stat_t stat,
    output epl_pkg::epl_cmd_t  cmd
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_DEC   = 10'b0000000010,
        S_MS1   = 10'b0000000100,
        S_MS2   = 10'b0000001000,
        S_MB1   = 10'b0000010000,
        S_MB2   = 10'b0000100000,
        S_UPD   = 10'b0001000000,
        S_DSTRT = 10'b0010000000,
        S_DRUN  = 10'b0100000000,
        S_FIN   = 10'b1000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] sel_reg, sel_next;
    logic       ovalid_reg, ovalid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            sel_reg    <= 2'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sel_reg    <= sel_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;

    always_comb
    begin
        state_next  = state_reg;
        sel_next    = sel_reg;
        ovalid_next = ovalid_reg && !out_ready;
        cmd         = '0;
        cmd.mul_op  = epl_pkg::OP_NONE;
        cmd.div_sel = sel_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (stat.is_flush)
                begin
                    sel_next   = 2'd0;
                    state_next = stat.empty ? S_FIN : S_DSTRT;
                end
                else
                begin
                    state_next = stat.at_limit ? S_IDLE : S_MS1;
                end
            end
            S_MS1:
            begin
                cmd.mul_op = epl_pkg::OP_MUL_S1;
                state_next = S_MS2;
            end
            S_MS2:
            begin
                cmd.mul_op = epl_pkg::OP_MUL_S2;
                state_next = S_MB1;
            end
            S_MB1:
            begin
                cmd.mul_op = epl_pkg::OP_MUL_B1;
                state_next = S_MB2;
            end
            S_MB2:
            begin
                cmd.mul_op = epl_pkg::OP_MUL_B2;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.sample_upd = 1'b1;
                state_next     = S_IDLE;
            end
            S_DSTRT:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DRUN;
            end
            S_DRUN:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    cmd.div_store = 1'b1;
                    sel_next      = sel_reg + 2'd1;
                    state_next    = (sel_reg == 2'd3) ? S_FIN : S_DSTRT;
                end
            end
            S_FIN:
            begin
                // wait until the previous result has left the output register
                if (!ovalid_reg || out_ready)
                begin
                    cmd.flush_done = 1'b1;
                    cmd.out_load   = 1'b1;
                    ovalid_next    = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/epl_dp.sv =====
// epl_dp: period sums, energy multiplier, shared serial divider, record packing
// depends on epl_pkg
module epl_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  epl_pkg::epl_cmd_t  cmd,
    output epl_pkg::epl_stat_t stat,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_idx,
    input  logic [19:0]        cfg_data,
    input  logic               req_type,
    input  logic [15:0]        solar_current,
    input  logic [15:0]        solar_voltage,
    input  logic signed [15:0] battery_current,
    input  logic [15:0]        battery_voltage,
    input  logic               mains_online,
    output logic               status,
    output logic [31:0]        log_record,
    output logic [7:0]         slot_index,
    output logic [63:0]        solar_energy,
    output logic [63:0]        charge_energy,
    output logic [63:0]        discharge_energy,
    output logic [15:0]        peak_solar_current,
    output logic [15:0]        peak_battery_voltage,
    output logic [15:0]        dark_battery_voltage,
    output logic [63:0]        total_solar_energy,
    output logic [63:0]        total_charge_energy,
    output logic [63:0]        total_discharge_energy
);

    localparam int CB = epl_pkg::COUNT_BITS;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

    // config
    logic [19:0] period_reg;
    logic        log_en_reg;

    // captured item
    logic        rt_reg, mains_reg;
    logic [15:0] sc_reg, sv_reg, bv_reg, bmag_reg;
    logic        bneg_reg;
    logic [15:0] bc_raw_reg;

    // period state
    logic [31:0] scs_reg, svs_reg, bcs_reg, bvs_reg;
    logic [CB-1:0] cnt_reg;
    logic [63:0] pse_reg, pce_reg, pde_reg;
    logic [15:0] ppc_reg, ppv_reg, pdv_reg;
    logic [63:0] tse_reg, tce_reg, tde_reg;
    logic [7:0]  slot_reg;

    // multiplier products
    logic [31:0] prod_s_reg, prod_b_reg;
    logic [63:0] es_reg, eb_reg;

    // divider
    logic [31:0] dq_reg;
    logic [CB:0] drem_reg;
    logic [5:0]  dcnt_reg;
    logic        dneg_reg;
    logic [31:0] avg_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= 20'd1000;
            log_en_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            if (cfg_idx == epl_pkg::CFG_PERIOD)
                period_reg <= cfg_data;
            else
                log_en_reg <= cfg_data[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rt_reg     <= req_type;
            mains_reg  <= mains_online;
            sc_reg     <= solar_current;
            sv_reg     <= solar_voltage;
            bv_reg     <= battery_voltage;
            bc_raw_reg <= battery_current;
            bneg_reg   <= battery_current[15];
            bmag_reg   <= battery_current[15] ? (16'd0 - battery_current) : battery_current;
        end
    end

    // multiplier: one 16x16 or 32x20 product per step, registered
    logic [15:0] bmag_fix;
    assign bmag_fix = bmag_reg; // 0x8000 magnitude fits in 16 bits unsigned
    always_ff @(posedge clk)
    begin
        case (cmd.mul_op)
            epl_pkg::OP_MUL_S1: prod_s_reg <= 32'(sc_reg) * 32'(sv_reg);
            epl_pkg::OP_MUL_S2: es_reg     <= 64'(prod_s_reg) * 64'(period_reg);
            epl_pkg::OP_MUL_B1: prod_b_reg <= 32'(bmag_fix) * 32'(bv_reg);
            epl_pkg::OP_MUL_B2: eb_reg     <= 64'(prod_b_reg) * 64'(period_reg);
            default: ;
        endcase
    end

    // divider: restoring, one quotient bit per cycle
    logic [31:0] dsrc;
    logic [CB:0] trial;
    logic [CB+1:0] shifted;
    always_comb
    begin
        case (cmd.div_sel)
            2'd0: dsrc = bcs_reg[31] ? (32'd0 - bcs_reg) : bcs_reg;
            2'd1: dsrc = scs_reg;
            2'd2: dsrc = svs_reg;
            default: dsrc = bvs_reg;
        endcase
        shifted = {drem_reg, dq_reg[31]};
        trial   = shifted[CB:0] - {1'b0, cnt_reg};
    end
    logic ge;
    assign ge = shifted >= {2'b00, cnt_reg};
    assign stat.div_last = (dcnt_reg == 6'd31);

    logic [31:0] qnext;
    assign qnext = {dq_reg[30:0], ge};

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            dq_reg   <= dsrc;
            drem_reg <= '0;
            dcnt_reg <= 6'd0;
            dneg_reg <= (cmd.div_sel == 2'd0) && bcs_reg[31];
        end
        else if (cmd.div_step)
        begin
            dq_reg   <= qnext;
            drem_reg <= ge ? trial : shifted[CB:0];
            dcnt_reg <= dcnt_reg + 6'd1;
        end
        if (cmd.div_store)
            avg_reg[cmd.div_sel] <= dneg_reg ? (32'd0 - qnext) : qnext;
    end

    assign stat.is_flush = rt_reg;
    assign stat.empty    = (cnt_reg == '0);
    assign stat.at_limit = (cnt_reg == epl_pkg::COUNT_LIMIT);

    // clamp and scale into record bytes
    // each scale is a reciprocal multiply and shift, exact over the clamped range
    logic signed [31:0] ba, sa, sva, bva;
    logic [15:0] bac, sac, svc, bvc;
    logic [7:0]  b0, b1, b2, b3;
    always_comb
    begin
        ba  = avg_reg[0];
        sa  = avg_reg[1];
        sva = avg_reg[2];
        bva = avg_reg[3];
        if (ba < -32'sd13000)      bac = 16'd0;
        else if (ba > 32'sd4000)   bac = 16'd17000;
        else                       bac = 16'(ba + 32'sd13000);
        svc = (avg_reg[2] > 32'd4000) ? 16'd4000 : avg_reg[2][15:0];
        sac = (avg_reg[1] > 32'd2500) ? 16'd2500 : avg_reg[1][15:0];
        if (avg_reg[3] < 32'd1900)      bvc = 16'd0;
        else if (avg_reg[3] > 32'd3000) bvc = 16'd1100;
        else                            bvc = 16'(avg_reg[3] - 32'd1900);
        b0 = 8'((32'(bac) * 32'd62915) >> 22);   // x * 255 / 17000
        b1 = 8'((32'(svc) * 32'd66847) >> 20);   // x * 255 / 4000
        b2 = 8'((32'(sac) * 32'd106955) >> 20);  // x * 255 / 2500
        b3 = {mains_reg, 7'((32'(bvc) * 32'd121063) >> 20)};  // x * 127 / 1100
    end

    logic [7:0] slot_inc;
    assign slot_inc = (slot_reg == 8'(epl_pkg::SLOTS - 1)) ? 8'd0 : slot_reg + 8'd1;

    logic [63:0] ntse, ntce, ntde;
    assign ntse = sat_add(tse_reg, pse_reg);
    assign ntce = sat_add(tce_reg, pce_reg);
    assign ntde = sat_add(tde_reg, pde_reg);

    logic [31:0] bc_ext;
    assign bc_ext = {{16{bc_raw_reg[15]}}, bc_raw_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scs_reg <= '0; svs_reg <= '0; bcs_reg <= '0; bvs_reg <= '0;
            cnt_reg <= '0;
            pse_reg <= '0; pce_reg <= '0; pde_reg <= '0;
            ppc_reg <= '0; ppv_reg <= '0; pdv_reg <= epl_pkg::DARK_RESET;
            tse_reg <= '0; tce_reg <= '0; tde_reg <= '0;
            slot_reg <= '0;
        end
        else if (cmd.sample_upd)
        begin
            scs_reg <= scs_reg + 32'(sc_reg);
            svs_reg <= svs_reg + 32'(sv_reg);
            bcs_reg <= bcs_reg + bc_ext;
            bvs_reg <= bvs_reg + 32'(bv_reg);
            cnt_reg <= cnt_reg + CB'(1);
            pse_reg <= sat_add(pse_reg, es_reg);
            if (bneg_reg) pde_reg <= sat_add(pde_reg, eb_reg);
            else          pce_reg <= sat_add(pce_reg, eb_reg);
            if (sc_reg > ppc_reg) ppc_reg <= sc_reg;
            if (bv_reg > ppv_reg) ppv_reg <= bv_reg;
            if (sv_reg < epl_pkg::DARK_LIMIT && bv_reg < pdv_reg) pdv_reg <= bv_reg;
        end
        else if (cmd.flush_done)
        begin
            if (!stat.empty)
            begin
                tse_reg  <= ntse;
                tce_reg  <= ntce;
                tde_reg  <= ntde;
                slot_reg <= slot_inc;
            end
            scs_reg <= '0; svs_reg <= '0; bcs_reg <= '0; bvs_reg <= '0;
            cnt_reg <= '0;
            pse_reg <= '0; pce_reg <= '0; pde_reg <= '0;
            ppc_reg <= '0; ppv_reg <= '0; pdv_reg <= epl_pkg::DARK_RESET;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status     <= stat.empty;
            slot_index <= slot_reg;
            if (stat.empty)
            begin
                log_record             <= '0;
                solar_energy           <= '0;
                charge_energy          <= '0;
                discharge_energy       <= '0;
                peak_solar_current     <= '0;
                peak_battery_voltage   <= '0;
                dark_battery_voltage   <= '0;
                total_solar_energy     <= tse_reg;
                total_charge_energy    <= tce_reg;
                total_discharge_energy <= tde_reg;
            end
            else
            begin
                log_record             <= {b3, b2, b1, b0};
                solar_energy           <= pse_reg;
                charge_energy          <= pce_reg;
                discharge_energy       <= pde_reg;
                peak_solar_current     <= ppc_reg;
                peak_battery_voltage   <= ppv_reg;
                dark_battery_voltage   <= pdv_reg;
                total_solar_energy     <= ntse;
                total_charge_energy    <= ntce;
                total_discharge_energy <= ntde;
            end
        end
    end

    // logging flag is kept for software, no effect on results
    logic unused_ok;
    assign unused_ok = log_en_reg & sa[0] & sva[0] & bva[0] & es_reg[0];

endmodule

// ===== rtl/core/energy_period_logger_top.sv =====
// energy_period_logger_top: top level, controller plus datapath
// depends on epl_pkg, epl_ctrl, epl_dp
//
// channel   | handshake              | payload
// ----------+------------------------+-------------------------------------
// input     | in_valid / in_ready    | req_type, sensor fields, mains_online
// output    | out_valid / out_ready  | status, log_record, slot, energies
// config    | cfg_we                 | cfg_idx, cfg_data
//
// a sample request runs a decode step, four multiplier steps and one update step
// a flush request runs four serial divisions, one per sum, then the finish step
// an empty flush skips the divisions; a sample at the count limit is not summed
// reset clears all period state and totals at once, no clearing pass
// a stalled output holds the finish step until the result register is free
module energy_period_logger_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_idx,
    input  logic [19:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               req_type,
    input  logic [15:0]        solar_current,
    input  logic [15:0]        solar_voltage,
    input  logic signed [15:0] battery_current,
    input  logic [15:0]        battery_voltage,
    input  logic               mains_online,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               status,
    output logic [31:0]        log_record,
    output logic [7:0]         slot_index,
    output logic [63:0]        solar_energy,
    output logic [63:0]        charge_energy,
    output logic [63:0]        discharge_energy,
    output logic [15:0]        peak_solar_current,
    output logic [15:0]        peak_battery_voltage,
    output logic [15:0]        dark_battery_voltage,
    output logic [63:0]        total_solar_energy,
    output logic [63:0]        total_charge_energy,
    output logic [63:0]        total_discharge_energy
);

    epl_pkg::epl_cmd_t  cmd;
    epl_pkg::epl_stat_t stat;

    // sequencing
    epl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // sums, multiplier, divider and result register
    epl_dp u_dp (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .cmd                    (cmd),
        .stat                   (stat),
        .cfg_we                 (cfg_we),
        .cfg_idx                (cfg_idx),
        .cfg_data               (cfg_data),
        .req_type               (req_type),
        .solar_current          (solar_current),
        .solar_voltage          (solar_voltage),
        .battery_current        (battery_current),
        .battery_voltage        (battery_voltage),
        .mains_online           (mains_online),
        .status                 (status),
        .log_record             (log_record),
        .slot_index             (slot_index),
        .solar_energy           (solar_energy),
        .charge_energy          (charge_energy),
        .discharge_energy       (discharge_energy),
        .peak_solar_current     (peak_solar_current),
        .peak_battery_voltage   (peak_battery_voltage),
        .dark_battery_voltage   (dark_battery_voltage),
        .total_solar_energy     (total_solar_energy),
        .total_charge_energy    (total_charge_energy),
        .total_discharge_energy (total_discharge_energy)
    );

endmodule

// ===== rtl/core/epl_checker.sv =====
// epl_checker: port-level assertions for the energy period logger
// depends on epl_pkg and energy_period_logger_top (bound to it)
module epl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        status,
    input logic [7:0]  slot_index,
    input logic [31:0] log_record
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(log_record))
        else $error("result dropped while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken twice in a row");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> slot_index < 8'(epl_pkg::SLOTS))
        else $error("slot index out of ring");

    a_skip_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> log_record == 32'd0)
        else $error("skipped period carries a record");

endmodule

bind energy_period_logger_top epl_checker u_epl_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .slot_index (slot_index),
    .log_record (log_record)
);
